// ===== hdl/hsl_pkg.sv =====
`default_nettype none

package hsl_pkg;

   // Piecewise-linear hue segment of one color channel.
   typedef logic [1:0] seg_type;

   localparam seg_type SEG_RISE = 2'd0;  // hue below 1/6: ramp up from p to q
   localparam seg_type SEG_HIGH = 2'd1;  // hue below 1/2: flat at q
   localparam seg_type SEG_FALL = 2'd2;  // hue below 2/3: ramp down from q to p
   localparam seg_type SEG_LOW  = 2'd3;  // remainder: flat at p

   // Number of register stages from input beat to result beat.
   localparam int NUM_STAGES = 5;

   // Channel order inside the per-channel arrays.
   localparam int CH_RED   = 0;
   localparam int CH_GREEN = 1;
   localparam int CH_BLUE  = 2;

endpackage : hsl_pkg

`default_nettype wire

// ===== hdl/hsl_to_rgb_core.sv =====
// HSL to RGB converter, fixed point with FRAC_BITS fraction bits.
// An accepted input beat passes the clamp, product, segment, multiply and select stages to its result beat.
// Throughput: one beat per cycle; each stage has its own valid bit and
// stalls only when its downstream stage is full and not moving.
// Reset (synchronous, active high) clears the stage valid bits only.
// The two multiplies (lightness by saturation, span by ramp) set the stage cut.
`default_nettype none

module hsl_to_rgb_core #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic signed [FRAC_BITS+1:0] req_hue,
   input  wire logic signed [FRAC_BITS+1:0] req_saturation,
   input  wire logic signed [FRAC_BITS+1:0] req_lightness,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic             [FRAC_BITS:0]   rsp_red,
   output logic             [FRAC_BITS:0]   rsp_green,
   output logic             [FRAC_BITS:0]   rsp_blue
);
   import hsl_pkg::*;

   // Unit values carry one integer bit; signed working values two more.
   localparam int UW = FRAC_BITS + 1;
   localparam int IN_W = FRAC_BITS + 2;
   localparam int SW = FRAC_BITS + 3;
   localparam int TW = UW + 3;
   localparam int PW = 2 * UW + 1;
   localparam int MW = SW + UW + 1;

   localparam logic [UW-1:0] ONE_U = UW'(1) << FRAC_BITS;
   localparam logic [UW-1:0] HALF_U = UW'(1) << (FRAC_BITS - 1);
   localparam logic [UW-1:0] THIRD_U = UW'(((1 << FRAC_BITS) + 1) / 3);
   localparam logic [TW-1:0] ONE_T = TW'(ONE_U);
   localparam logic [TW-1:0] TWO_T = TW'(ONE_U) << 1;
   localparam logic [TW-1:0] FOUR_T = TW'(ONE_U) << 2;
   localparam logic signed [SW-1:0] ONE_S = SW'(ONE_U);

   // Clamp a signed input field into 0 .. 1.0.
   function automatic logic [UW-1:0] clamp_in(input logic [IN_W-1:0] v);
      logic [UW-1:0] mag;
      mag = v[UW-1:0];
      if (v[IN_W-1]) begin
         return '0;
      end else if (mag > ONE_U) begin
         return ONE_U;
      end
      return mag;
   endfunction

   // Clamp a signed channel value into 0 .. 1.0.
   function automatic logic [UW-1:0] clamp_ch(input logic signed [SW-1:0] v);
      if (v < 0) begin
         return '0;
      end else if (v > ONE_S) begin
         return ONE_U;
      end
      return v[UW-1:0];
   endfunction

   // ---------------------------------------------------------------
   // Stage handshake: a stage loads when it is empty or drains.
   // ---------------------------------------------------------------
   logic [NUM_STAGES-1:0] vld_ff;
   logic [NUM_STAGES:0]   rdy;

   always_comb begin
      rdy[NUM_STAGES] = rsp_ready;
      for (int k = NUM_STAGES - 1; k >= 0; k--) begin
         rdy[k] = !vld_ff[k] || rdy[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (rdy[0]) begin
            vld_ff[0] <= req_valid;
         end
         for (int k = 1; k < NUM_STAGES; k++) begin
            if (rdy[k]) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end
      end
   end

   assign req_ready = rdy[0];
   assign rsp_valid = vld_ff[NUM_STAGES-1];

   // ---------------------------------------------------------------
   // Stage 1: clamp the three inputs.
   // ---------------------------------------------------------------
   logic [UW-1:0] h1_ff, s1_ff, l1_ff;
   logic [UW-1:0] h1_in, s1_in, l1_in;

   assign h1_in = clamp_in(req_hue);
   assign s1_in = clamp_in(req_saturation);
   assign l1_in = clamp_in(req_lightness);

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         h1_ff <= h1_in;
         s1_ff <= s1_in;
         l1_ff <= l1_in;
      end
   end

   // ---------------------------------------------------------------
   // Stage 2: lightness product for q, and the wrapped channel hues.
   // ---------------------------------------------------------------
   logic [PW-1:0]        prod2_ff, prod2_in;
   logic                 lo2_ff, lo2_in;
   logic [UW-1:0]        s2_ff, l2_ff;
   logic [2:0][UW-1:0]   t2_ff, t2_in;
   logic [UW:0]          mult2;
   logic [UW:0]          hp2;

   always_comb begin
      // Dark half uses l * (1 + s), light half uses l * s.
      lo2_in = (l1_ff <= HALF_U);
      mult2 = lo2_in ? ({1'b0, ONE_U} + {1'b0, s1_ff}) : {1'b0, s1_ff};
      prod2_in = PW'(l1_ff * mult2);

      // Red hue is h + 1/3, blue hue is h - 1/3, both wrapped once.
      hp2 = {1'b0, h1_ff} + {1'b0, THIRD_U};
      if (hp2 > {1'b0, ONE_U}) begin
         t2_in[CH_RED] = UW'(hp2 - {1'b0, ONE_U});
      end else begin
         t2_in[CH_RED] = UW'(hp2);
      end
      t2_in[CH_GREEN] = h1_ff;
      if (h1_ff < THIRD_U) begin
         t2_in[CH_BLUE] = h1_ff + ONE_U - THIRD_U;
      end else begin
         t2_in[CH_BLUE] = h1_ff - THIRD_U;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         prod2_ff <= prod2_in;
         lo2_ff   <= lo2_in;
         s2_ff    <= s1_ff;
         l2_ff    <= l1_ff;
         t2_ff    <= t2_in;
      end
   end

   // ---------------------------------------------------------------
   // Stage 3: q, p and span, plus segment and ramp factor per channel.
   // ---------------------------------------------------------------
   logic signed [SW-1:0] q3_ff, p3_ff, d3_ff;
   logic signed [SW-1:0] q3_in, p3_in, d3_in;
   logic [2:0][UW-1:0]   f3_ff, f3_in;
   seg_type [2:0]        seg3_ff, seg3_in;
   logic [UW-1:0]        l3_ff;
   logic                 black3_ff, grey3_ff;
   logic signed [SW-1:0] pt3, l3s, s3s;
   logic [TW-1:0]        t6;
   logic [TW-1:0]        fall6;

   always_comb begin
      pt3 = SW'(prod2_ff >> FRAC_BITS);
      l3s = SW'(l2_ff);
      s3s = SW'(s2_ff);
      q3_in = lo2_ff ? pt3 : (l3s + s3s - pt3);
      p3_in = (l3s <<< 1) - q3_in;
      d3_in = q3_in - p3_in;

      for (int c = 0; c < 3; c++) begin
         t6 = TW'(t2_ff[c]) * TW'(6);
         fall6 = FOUR_T - t6;
         f3_in[c] = '0;
         if (t6 < ONE_T) begin
            seg3_in[c] = SEG_RISE;
            f3_in[c] = t6[UW-1:0];
         end else if ((TW'(t2_ff[c]) << 1) < ONE_T) begin
            seg3_in[c] = SEG_HIGH;
         end else if (TW'(t2_ff[c]) * TW'(3) < TWO_T) begin
            seg3_in[c] = SEG_FALL;
            f3_in[c] = fall6[UW-1:0];
         end else begin
            seg3_in[c] = SEG_LOW;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[2]) begin
         q3_ff     <= q3_in;
         p3_ff     <= p3_in;
         d3_ff     <= d3_in;
         f3_ff     <= f3_in;
         seg3_ff   <= seg3_in;
         l3_ff     <= l2_ff;
         black3_ff <= (l2_ff == '0);
         grey3_ff  <= (s2_ff == '0);
      end
   end

   // ---------------------------------------------------------------
   // Stage 4: span times ramp factor, one multiplier per channel.
   // ---------------------------------------------------------------
   logic signed [2:0][MW-1:0] m4_ff, m4_in;
   logic signed [SW-1:0]      q4_ff, p4_ff;
   seg_type [2:0]             seg4_ff;
   logic [UW-1:0]             l4_ff;
   logic                      black4_ff, grey4_ff;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         m4_in[c] = MW'(d3_ff * $signed({1'b0, f3_ff[c]}));
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[3]) begin
         m4_ff     <= m4_in;
         q4_ff     <= q3_ff;
         p4_ff     <= p3_ff;
         seg4_ff   <= seg3_ff;
         l4_ff     <= l3_ff;
         black4_ff <= black3_ff;
         grey4_ff  <= grey3_ff;
      end
   end

   // ---------------------------------------------------------------
   // Stage 5: pick each channel by segment, apply black and grey.
   // ---------------------------------------------------------------
   logic [2:0][UW-1:0]   ch5_ff, ch5_in;
   logic signed [SW-1:0] ramp5;
   logic signed [SW-1:0] sel5;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         // Products are never negative, so the shift truncates toward zero.
         ramp5 = p4_ff + SW'($signed(m4_ff[c]) >>> FRAC_BITS);
         case (seg4_ff[c]) inside
            SEG_RISE, SEG_FALL: sel5 = ramp5;
            SEG_HIGH:           sel5 = q4_ff;
            default:            sel5 = p4_ff;
         endcase
         if (black4_ff) begin
            ch5_in[c] = '0;
         end else if (grey4_ff) begin
            ch5_in[c] = l4_ff;
         end else begin
            ch5_in[c] = clamp_ch(sel5);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[4]) begin
         ch5_ff <= ch5_in;
      end
   end

   assign rsp_red   = ch5_ff[CH_RED];
   assign rsp_green = ch5_ff[CH_GREEN];
   assign rsp_blue  = ch5_ff[CH_BLUE];

   // ---------------------------------------------------------------
   // Assertions.
   // ---------------------------------------------------------------

   // A full pipe facing a stalled output cannot take a new beat.
   assert property (@(posedge clock) disable iff (reset)
      ((&vld_ff) && !rsp_ready) |-> !req_ready)
      else $error("input accepted while pipeline is full and stalled");

   // Backpressure at the input only comes from an occupied first stage.
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> vld_ff[0])
      else $error("input stalled with an empty first stage");

   // Every delivered channel stays within 0 .. 1.0.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_red <= ONE_U) && (rsp_green <= ONE_U) && (rsp_blue <= ONE_U))
      else $error("channel out of unit range");

   // A result left waiting still sits in the last stage in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (vld_ff[NUM_STAGES-1] && !rsp_ready) |=> $stable(ch5_ff))
      else $error("waiting result changed in last stage");

   // Reset leaves the pipeline empty.
   assert property (@(posedge clock)
      reset |=> (vld_ff == '0))
      else $error("stage valid bits not cleared by reset");

endmodule : hsl_to_rgb_core

`default_nettype wire
